// ===== hw/rtl/spcm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spcm_pkg
// Shared widths, payload words and command codes of the peaking-cut mixer.
// ----------------------------------------------------------------------------
package spcm_pkg;

    localparam int SAMPLE_BITS    = 24;
    localparam int COEF_BITS      = 25;
    localparam int COEF_FRAC_BITS = 22;
    localparam int FILT_BITS      = SAMPLE_BITS + 2;
    localparam int AMOUNT_BITS    = 25;
    localparam int AMOUNT_FRAC    = 24;
    localparam int TARGET_BITS    = 17;
    localparam int TARGET_SHIFT   = AMOUNT_FRAC - (TARGET_BITS - 1);
    localparam int CFG_IDX_BITS   = 3;
    localparam int CFG_DATA_BITS  = 25;

    localparam int MUL_A_BITS = FILT_BITS + 1;
    localparam int MUL_B_BITS = COEF_BITS + 1;
    localparam int PROD_BITS  = MUL_A_BITS + MUL_B_BITS;
    localparam int ACC_BITS   = PROD_BITS + 3;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_in;
        logic [TARGET_BITS-1:0]        blend_target;
        logic                          end_of_block;
    } t_in_word;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_out;
        logic                          end_of_block_out;
    } t_out_word;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_B0     = 3'd0,
        CFG_B1     = 3'd1,
        CFG_B2     = 3'd2,
        CFG_A1     = 3'd3,
        CFG_A2     = 3'd4,
        CFG_SMOOTH = 3'd5
    } t_cfg_idx;

    typedef enum logic [2:0] {
        MS_B0,
        MS_B1,
        MS_B2,
        MS_A1,
        MS_A2,
        MS_SMO,
        MS_MIX
    } t_mul_sel;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD,
        ACC_SUB
    } t_acc_op;

    typedef struct packed {
        logic     load_in;
        logic     mul_en;
        t_mul_sel mul_sel;
        t_acc_op  acc_op;
        logic     upd_state;
        logic     load_out;
    } t_dp_cmd;

endpackage
`default_nettype wire

// ===== hw/rtl/spcm_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spcm_ctrl
// Sequencer: steps the shared multiplier through the filter taps, the
// smoother and the mix, and owns the input and output handshakes.
// ----------------------------------------------------------------------------
module spcm_ctrl (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  wire               i_out_ready,
    output spcm_pkg::t_dp_cmd o_cmd
);
    import spcm_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_B0,
        S_B1,
        S_B2,
        S_A1,
        S_A2,
        S_SMO,
        S_UPD,
        S_MIX,
        S_RES
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    t_dp_cmd cmd;

    always_comb begin
        cmd         = '0;
        cmd.mul_sel = MS_B0;
        cmd.acc_op  = ACC_HOLD;
        n_state     = r_state;
        unique case (r_state)
            S_IDLE: begin
                cmd.load_in = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_B0;
                end
            end
            S_B0: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MS_B0;
                n_state     = S_B1;
            end
            S_B1: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MS_B1;
                cmd.acc_op  = ACC_LOAD;
                n_state     = S_B2;
            end
            S_B2: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MS_B2;
                cmd.acc_op  = ACC_ADD;
                n_state     = S_A1;
            end
            S_A1: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MS_A1;
                cmd.acc_op  = ACC_ADD;
                n_state     = S_A2;
            end
            S_A2: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MS_A2;
                cmd.acc_op  = ACC_SUB;
                n_state     = S_SMO;
            end
            S_SMO: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MS_SMO;
                cmd.acc_op  = ACC_SUB;
                n_state     = S_UPD;
            end
            S_UPD: begin
                cmd.upd_state = 1'b1;
                n_state       = S_MIX;
            end
            S_MIX: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MS_MIX;
                n_state     = S_RES;
            end
            S_RES: begin
                cmd.load_out = !r_out_valid || i_out_ready;
                if (!r_out_valid || i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

endmodule
`default_nettype wire

// ===== hw/rtl/spcm_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spcm_dp
// Datapath: coefficient registers, filter and smoother state, one shared
// signed multiplier, accumulator, rounding and saturation, output word.
// ----------------------------------------------------------------------------
module spcm_dp (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_cfg_wr_en,
    input  wire [spcm_pkg::CFG_IDX_BITS-1:0]     i_cfg_index,
    input  wire [spcm_pkg::CFG_DATA_BITS-1:0]    i_cfg_wdata,
    input  spcm_pkg::t_in_word                   i_in_word,
    input  spcm_pkg::t_dp_cmd                    i_cmd,
    output spcm_pkg::t_out_word                  o_out_word
);
    import spcm_pkg::*;

    localparam logic [AMOUNT_BITS-1:0] AMOUNT_ONE = AMOUNT_BITS'(1) << AMOUNT_FRAC;
    localparam logic [TARGET_BITS-1:0] TARGET_ONE = TARGET_BITS'(1) << (TARGET_BITS - 1);
    localparam logic signed [COEF_BITS-1:0] B0_RESET = COEF_BITS'(1) << COEF_FRAC_BITS;
    localparam logic [AMOUNT_BITS-1:0] SMOOTH_RESET = AMOUNT_BITS'(19406);

    localparam logic signed [ACC_BITS-1:0] ACC_HALF =
        ACC_BITS'(1) << (COEF_FRAC_BITS - 1);
    localparam logic signed [PROD_BITS-1:0] PROD_HALF =
        PROD_BITS'(1) << (AMOUNT_FRAC - 1);
    localparam logic signed [ACC_BITS-1:0] Y_MAX =
        {{(ACC_BITS-FILT_BITS+1){1'b0}}, {(FILT_BITS-1){1'b1}}};
    localparam logic signed [ACC_BITS-1:0] Y_MIN =
        {{(ACC_BITS-FILT_BITS+1){1'b1}}, {(FILT_BITS-1){1'b0}}};
    localparam logic signed [PROD_BITS-1:0] S_MAX =
        {{(PROD_BITS-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [PROD_BITS-1:0] S_MIN =
        {{(PROD_BITS-SAMPLE_BITS+1){1'b1}}, {(SAMPLE_BITS-1){1'b0}}};
    localparam logic signed [PROD_BITS-1:0] AMT_ONE_EXT = PROD_BITS'(AMOUNT_ONE);

    logic signed [COEF_BITS-1:0]   r_b0, r_b1, r_b2, r_a1, r_a2;
    logic [AMOUNT_BITS-1:0]        r_factor;

    logic signed [SAMPLE_BITS-1:0] r_x1, r_x2;
    logic signed [FILT_BITS-1:0]   r_y1, r_y2;
    logic [AMOUNT_BITS-1:0]        r_amount;

    logic signed [SAMPLE_BITS-1:0] r_x;
    logic [AMOUNT_BITS-1:0]        r_target;
    logic                          r_eob;
    logic signed [PROD_BITS-1:0]   r_prod;
    logic signed [ACC_BITS-1:0]    r_acc;
    t_out_word                     r_out_word;

    logic [TARGET_BITS-1:0]        target_c;
    logic [AMOUNT_BITS-1:0]        factor_c;
    logic signed [FILT_BITS-1:0]   smo_diff;
    logic signed [MUL_A_BITS-1:0]  op_a;
    logic signed [MUL_B_BITS-1:0]  op_b;
    logic signed [PROD_BITS-1:0]   prod;
    logic signed [ACC_BITS-1:0]    acc_sh;
    logic signed [FILT_BITS-1:0]   y_sat;
    logic signed [PROD_BITS-1:0]   prod_step;
    logic signed [PROD_BITS-1:0]   amt_sum;
    logic [AMOUNT_BITS-1:0]        amt_new;
    logic signed [PROD_BITS-1:0]   res_sum;
    logic signed [SAMPLE_BITS-1:0] res_sat;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b0     <= B0_RESET;
            r_b1     <= '0;
            r_b2     <= '0;
            r_a1     <= '0;
            r_a2     <= '0;
            r_factor <= SMOOTH_RESET;
        end else if (i_cfg_wr_en) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_B0:     r_b0     <= $signed(i_cfg_wdata);
                CFG_B1:     r_b1     <= $signed(i_cfg_wdata);
                CFG_B2:     r_b2     <= $signed(i_cfg_wdata);
                CFG_A1:     r_a1     <= $signed(i_cfg_wdata);
                CFG_A2:     r_a2     <= $signed(i_cfg_wdata);
                CFG_SMOOTH: r_factor <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign target_c = (i_in_word.blend_target > TARGET_ONE) ? TARGET_ONE
                                                            : i_in_word.blend_target;
    assign factor_c = (r_factor > AMOUNT_ONE) ? AMOUNT_ONE : r_factor;
    assign smo_diff = $signed({1'b0, r_target}) - $signed({1'b0, r_amount});

    always_comb begin
        case (i_cmd.mul_sel)
            MS_B0: begin
                op_a = MUL_A_BITS'(r_x);
                op_b = MUL_B_BITS'(r_b0);
            end
            MS_B1: begin
                op_a = MUL_A_BITS'(r_x1);
                op_b = MUL_B_BITS'(r_b1);
            end
            MS_B2: begin
                op_a = MUL_A_BITS'(r_x2);
                op_b = MUL_B_BITS'(r_b2);
            end
            MS_A1: begin
                op_a = MUL_A_BITS'(r_y1);
                op_b = MUL_B_BITS'(r_a1);
            end
            MS_A2: begin
                op_a = MUL_A_BITS'(r_y2);
                op_b = MUL_B_BITS'(r_a2);
            end
            MS_SMO: begin
                op_a = MUL_A_BITS'(smo_diff);
                op_b = $signed({1'b0, factor_c});
            end
            MS_MIX: begin
                op_a = MUL_A_BITS'(r_y1) - MUL_A_BITS'(r_x);
                op_b = $signed({1'b0, r_amount});
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    assign prod = op_a * op_b;

    // filter output: round at the coefficient point, saturate
    assign acc_sh = (r_acc + ACC_HALF) >>> COEF_FRAC_BITS;
    always_comb begin
        if (acc_sh > Y_MAX) begin
            y_sat = Y_MAX[FILT_BITS-1:0];
        end else if (acc_sh < Y_MIN) begin
            y_sat = Y_MIN[FILT_BITS-1:0];
        end else begin
            y_sat = acc_sh[FILT_BITS-1:0];
        end
    end

    // smoother step and mix share the Q1.24 rounding
    assign prod_step = (r_prod + PROD_HALF) >>> AMOUNT_FRAC;
    assign amt_sum   = $signed(PROD_BITS'(r_amount)) + prod_step;
    always_comb begin
        if (amt_sum < 0) begin
            amt_new = '0;
        end else if (amt_sum > AMT_ONE_EXT) begin
            amt_new = AMOUNT_ONE;
        end else begin
            amt_new = amt_sum[AMOUNT_BITS-1:0];
        end
    end

    assign res_sum = PROD_BITS'(r_x) + prod_step;
    always_comb begin
        if (res_sum > S_MAX) begin
            res_sat = S_MAX[SAMPLE_BITS-1:0];
        end else if (res_sum < S_MIN) begin
            res_sat = S_MIN[SAMPLE_BITS-1:0];
        end else begin
            res_sat = res_sum[SAMPLE_BITS-1:0];
        end
    end

    // filter and smoother state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x1     <= '0;
            r_x2     <= '0;
            r_y1     <= '0;
            r_y2     <= '0;
            r_amount <= '0;
        end else if (i_cmd.upd_state) begin
            r_x1     <= r_x;
            r_x2     <= r_x1;
            r_y1     <= y_sat;
            r_y2     <= r_y1;
            r_amount <= amt_new;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_x      <= i_in_word.sample_in;
            r_target <= {target_c, TARGET_SHIFT'(0)};
            r_eob    <= i_in_word.end_of_block;
        end
        if (i_cmd.mul_en) begin
            r_prod <= prod;
        end
        case (i_cmd.acc_op)
            ACC_LOAD: r_acc <= ACC_BITS'(r_prod);
            ACC_ADD:  r_acc <= r_acc + ACC_BITS'(r_prod);
            ACC_SUB:  r_acc <= r_acc - ACC_BITS'(r_prod);
            default:  r_acc <= r_acc;
        endcase
        if (i_cmd.load_out) begin
            r_out_word.sample_out       <= res_sat;
            r_out_word.end_of_block_out <= r_eob;
        end
    end

    assign o_out_word = r_out_word;

endmodule
`default_nettype wire

// ===== hw/rtl/smoothed_peaking_cut_mixer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// smoothed_peaking_cut_mixer
// Direct form I biquad peaking cut with a one-pole smoothed wet/dry blend.
// ----------------------------------------------------------------------------
// Each input word is taken when the block is idle; its result word is loaded
// into the output register once the output side has taken the previous one,
// and only then does the block take the next word, so words are worked one
// at a time. The pace is set by one shared 27x26 signed multiplier that
// forms seven products per sample (five filter taps, the smoother step and
// the mix), each product registered before it is accumulated or rounded. The
// output register lets a finished word wait while the next one is taken in.
// Coefficient writes go straight to their registers.
module smoothed_peaking_cut_mixer (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_cfg_wr_en,
    input  wire [spcm_pkg::CFG_IDX_BITS-1:0]     i_cfg_index,
    input  wire [spcm_pkg::CFG_DATA_BITS-1:0]    i_cfg_wdata,
    input  wire                                  i_in_valid,
    output logic                                 o_in_ready,
    input  spcm_pkg::t_in_word                   i_in_word,
    output logic                                 o_out_valid,
    input  wire                                  i_out_ready,
    output spcm_pkg::t_out_word                  o_out_word
);
    import spcm_pkg::*;

    t_dp_cmd w_cmd;

    spcm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (w_cmd)
    );

    spcm_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_word   (i_in_word),
        .i_cmd       (w_cmd),
        .o_out_word  (o_out_word)
    );

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("block still ready after taking a word");

    a_idle_on_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> o_in_ready)
        else $error("result shown while sequencer still busy");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load_out |-> (!o_out_valid || i_out_ready))
        else $error("pending output word overwritten");

endmodule
`default_nettype wire

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives sample words through the peaking-cut mixer under random stalls on
// both sides, predicts each result word from a bit-true software model of the
// biquad, the blend smoother and the saturating mix, and checks every result
// word in order. Coefficients are reloaded between phases while idle.
// ----------------------------------------------------------------------------
module testbench;

    import spcm_pkg::*;

    localparam int     TARGET_ONE   = 1 << (TARGET_BITS - 1);
    localparam longint AMOUNT_ONE   = 64'sd1 <<< AMOUNT_FRAC;
    localparam int     COEF_ONE     = 1 << COEF_FRAC_BITS;
    localparam int     COEF_MAX     = (1 << (COEF_BITS - 1)) - 1;
    localparam int     COEF_MIN     = -(1 << (COEF_BITS - 1));
    localparam int     RESET_SMOOTH = 19406;
    localparam int     IDLE_PCT     = 17;
    localparam int     TAIL_CYCLES  = 12;

    localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_B = 3'd7;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                     cfg_wr_en = 1'b0;
    logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] cfg_wdata = '0;

    logic      in_valid  = 1'b0;
    t_in_word  in_word   = '0;
    logic      in_ready;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_word out_word;

    logic calm = 1'b0;

    smoothed_peaking_cut_mixer uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_wr_en (cfg_wr_en),
        .i_cfg_index (cfg_index),
        .i_cfg_wdata (cfg_wdata),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_word  (out_word)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // filter and blend model state
    logic signed [COEF_BITS-1:0]   tap_b0 = COEF_BITS'(COEF_ONE);
    logic signed [COEF_BITS-1:0]   tap_b1 = '0;
    logic signed [COEF_BITS-1:0]   tap_b2 = '0;
    logic signed [COEF_BITS-1:0]   tap_a1 = '0;
    logic signed [COEF_BITS-1:0]   tap_a2 = '0;
    logic [COEF_BITS-1:0]          smooth_step = COEF_BITS'(RESET_SMOOTH);
    logic signed [SAMPLE_BITS-1:0] x_hist1 = '0;
    logic signed [SAMPLE_BITS-1:0] x_hist2 = '0;
    logic signed [FILT_BITS-1:0]   y_hist1 = '0;
    logic signed [FILT_BITS-1:0]   y_hist2 = '0;
    logic [AMOUNT_BITS-1:0]        blend_amt = '0;

    t_in_word  pending_words[$];
    t_out_word expected_words[$];
    int        queued_words   = 0;
    int        accepted_words = 0;
    int        mismatches     = 0;
    logic      in_fire;

    function automatic longint round_q(input longint v, input int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic longint clamp_signed(input longint v, input int w);
        longint hi;
        longint lo;
        hi = (64'sd1 <<< (w - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) return hi;
        if (v < lo) return lo;
        return v;
    endfunction

    task automatic predict_mix(input t_in_word w);
        longint x, acc, y, tgt, fac, amt, mix, res;
        t_out_word r;
        x   = $signed(w.sample_in);
        acc = longint'(tap_b0) * x
            + longint'(tap_b1) * longint'(x_hist1)
            + longint'(tap_b2) * longint'(x_hist2)
            - longint'(tap_a1) * longint'(y_hist1)
            - longint'(tap_a2) * longint'(y_hist2);
        y = clamp_signed(round_q(acc, COEF_FRAC_BITS), FILT_BITS);
        x_hist2 = x_hist1;
        x_hist1 = x[SAMPLE_BITS-1:0];
        y_hist2 = y_hist1;
        y_hist1 = y[FILT_BITS-1:0];

        if (w.blend_target > TARGET_ONE) tgt = TARGET_ONE;
        else tgt = longint'(w.blend_target);
        tgt = tgt <<< TARGET_SHIFT;
        fac = (smooth_step > AMOUNT_ONE) ? AMOUNT_ONE : longint'(smooth_step);
        amt = longint'(blend_amt);
        amt = amt + round_q((tgt - amt) * fac, AMOUNT_FRAC);
        if (amt < 0) amt = 0;
        if (amt > AMOUNT_ONE) amt = AMOUNT_ONE;
        blend_amt = amt[AMOUNT_BITS-1:0];

        mix = round_q((y - x) * amt, AMOUNT_FRAC);
        res = clamp_signed(x + mix, SAMPLE_BITS);
        r.sample_out       = res[SAMPLE_BITS-1:0];
        r.end_of_block_out = w.end_of_block;
        expected_words.push_back(r);
    endtask

    // sender
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            in_fire = in_valid && in_ready;
            if (in_fire) begin
                predict_mix(in_word);
                accepted_words++;
            end
            if (in_valid && !in_fire) begin
                // hold the word until taken
            end else if (pending_words.size() > 0
                         && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
                in_word  <= pending_words.pop_front();
                in_valid <= 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // receiver and checker
    always @(posedge clk) begin
        t_out_word want;
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                if (expected_words.size() == 0) begin
                    $error("result word with none expected: sample_out %0d",
                           $signed(out_word.sample_out));
                    mismatches++;
                end else begin
                    want = expected_words.pop_front();
                    if (out_word.sample_out !== want.sample_out) begin
                        $error("sample_out: expected %0d, got %0d",
                               $signed(want.sample_out), $signed(out_word.sample_out));
                        mismatches++;
                    end
                    if (out_word.end_of_block_out !== want.end_of_block_out) begin
                        $error("end_of_block_out: expected %0b, got %0b",
                               want.end_of_block_out, out_word.end_of_block_out);
                        mismatches++;
                    end
                end
            end
            out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    task automatic queue_word(input int sample, input int target, input bit eob);
        t_in_word w;
        w.sample_in    = SAMPLE_BITS'(sample);
        w.blend_target = TARGET_BITS'(target);
        w.end_of_block = eob;
        pending_words.push_back(w);
        queued_words++;
    endtask

    task automatic wait_drained();
        while (accepted_words != queued_words || expected_words.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input int data);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= CFG_DATA_BITS'(data);
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        case (idx)
            CFG_B0:     tap_b0 = COEF_BITS'(data);
            CFG_B1:     tap_b1 = COEF_BITS'(data);
            CFG_B2:     tap_b2 = COEF_BITS'(data);
            CFG_A1:     tap_a1 = COEF_BITS'(data);
            CFG_A2:     tap_a2 = COEF_BITS'(data);
            CFG_SMOOTH: smooth_step = COEF_BITS'(data);
            default: ;
        endcase
    endtask

    task automatic write_taps(input int b0, input int b1, input int b2,
                              input int a1, input int a2, input int smooth);
        write_reg(CFG_B0, b0);
        write_reg(CFG_B1, b1);
        write_reg(CFG_B2, b2);
        write_reg(CFG_A1, a1);
        write_reg(CFG_A2, a2);
        write_reg(CFG_SMOOTH, smooth);
    endtask

    function automatic int pick_extreme();
        return ($urandom_range(0, 1) == 1) ? COEF_MAX : COEF_MIN;
    endfunction

    task automatic load_random_taps(input int style);
        int b0, b1, b2, a1, a2, smooth, cut;
        case (style)
            0: begin
                // plausible peaking cut around unity gain
                cut = $urandom_range(0, 600000);
                a1  = -($urandom_range(5000000, 8000000));
                a2  = $urandom_range(2500000, 4100000);
                b0  = COEF_ONE - cut;
                b1  = a1;
                b2  = a2 - cut;
            end
            1: begin
                b0 = $urandom_range(0, COEF_MAX) - $urandom_range(0, 1) * (COEF_MAX + 1);
                b1 = $urandom_range(0, COEF_MAX) - $urandom_range(0, 1) * (COEF_MAX + 1);
                b2 = $urandom_range(0, COEF_MAX) - $urandom_range(0, 1) * (COEF_MAX + 1);
                a1 = $urandom_range(0, COEF_MAX) - $urandom_range(0, 1) * (COEF_MAX + 1);
                a2 = $urandom_range(0, COEF_MAX) - $urandom_range(0, 1) * (COEF_MAX + 1);
            end
            default: begin
                b0 = pick_extreme();
                b1 = pick_extreme();
                b2 = pick_extreme();
                a1 = pick_extreme();
                a2 = pick_extreme();
            end
        endcase
        case ($urandom_range(0, 4))
            0:       smooth = 0;
            1:       smooth = 1 << AMOUNT_FRAC;
            2:       smooth = $urandom_range(0, (1 << CFG_DATA_BITS) - 1);
            default: smooth = $urandom_range(1000, 400000);
        endcase
        write_taps(b0, b1, b2, a1, a2, smooth);
        if ($urandom_range(0, 2) == 0)
            write_reg($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B, $urandom);
    endtask

    // audio-like stream: held targets that the smoother chases, block marks
    task automatic queue_stream(input int count);
        int target, hold, block_len, pos, sample, kind;
        hold = 0;
        pos = 0;
        block_len = $urandom_range(4, 64);
        target = 0;
        for (int k = 0; k < count; k++) begin
            if (hold == 0) begin
                hold = $urandom_range(1, 40);
                kind = $urandom_range(0, 19);
                if (kind < 14)      target = $urandom_range(0, TARGET_ONE);
                else if (kind < 16) target = 0;
                else if (kind < 17) target = TARGET_ONE;
                else                target = $urandom_range(TARGET_ONE + 1,
                                                         (1 << TARGET_BITS) - 1);
            end
            hold--;
            kind = $urandom_range(0, 9);
            if (kind < 5)       sample = $urandom;
            else if (kind < 8)  sample = $urandom_range(0, 131071) - 65536;
            else if (kind == 8) sample = $urandom_range(0, 1) ? 8388607 : -8388608;
            else                sample = 0;
            pos++;
            if (pos == block_len) begin
                queue_word(sample, target, 1'b1);
                pos = 0;
                block_len = $urandom_range(4, 64);
            end else begin
                queue_word(sample, target, $urandom_range(0, 49) == 0);
            end
        end
    endtask

    initial begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset taps: pass-through filter, slow blend
        queue_word(0, 0, 1'b0);
        queue_word(8388607, TARGET_ONE, 1'b1);
        queue_word(-8388608, (1 << TARGET_BITS) - 1, 1'b0);
        queue_word(-1, TARGET_ONE + 1, 1'b1);
        queue_word(1, 0, 1'b0);
        wait_drained();

        // extreme taps with instant blend: filter and result overflow
        write_taps(COEF_MAX, COEF_MIN, COEF_MAX, COEF_MIN, COEF_MAX, 1 << AMOUNT_FRAC);
        write_reg(CFG_SPARE_A, '1);
        write_reg(CFG_SPARE_B, COEF_ONE);
        queue_word(8388607, TARGET_ONE, 1'b0);
        queue_word(-8388608, TARGET_ONE, 1'b0);
        queue_word(8388607, (1 << TARGET_BITS) - 1, 1'b1);
        queue_word(-8388608, 0, 1'b0);
        queue_word(8388607, TARGET_ONE, 1'b0);
        queue_word(0, TARGET_ONE + 1, 1'b1);
        wait_drained();

        // step above one, all taps at the negative limit
        write_taps(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN,
                   (1 << CFG_DATA_BITS) - 1);
        queue_word(8388607, TARGET_ONE, 1'b0);
        queue_word(-8388608, 32768, 1'b0);
        queue_word(4194304, TARGET_ONE, 1'b1);
        queue_word(-1, 0, 1'b0);
        queue_word(8388607, (1 << TARGET_BITS) - 1, 1'b0);
        wait_drained();

        // zero step: blend frozen
        write_taps(COEF_ONE, 0, 0, 0, 0, 0);
        queue_word(8388607, TARGET_ONE, 1'b0);
        queue_word(-8388608, TARGET_ONE, 1'b1);
        queue_word(123456, 0, 1'b0);
        wait_drained();

        for (int phase = 0; phase < 8; phase++) begin
            load_random_taps(phase % 3);
            if (phase == 4) calm <= 1'b1;
            queue_stream(191);
            wait_drained();
            calm <= 1'b0;
        end

        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule

// ===== smoothed_peaking_cut_mixer.f =====
hw/rtl/spcm_pkg.sv
hw/rtl/spcm_ctrl.sv
hw/rtl/spcm_dp.sv
hw/rtl/smoothed_peaking_cut_mixer.sv
sim/testbench.sv
